// ===== sv/failover_pair_state_machine_unit_defines.svh =====
// Assertion macros for the failover pair role unit checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef FAILOVER_PAIR_STATE_MACHINE_UNIT_DEFINES_SVH
`define FAILOVER_PAIR_STATE_MACHINE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fpsm_pkg.sv =====
// Shared types and codes for the failover pair role unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fpsm_pkg;

  typedef enum logic [2:0] {
    ROLE_NONE    = 3'd0,
    ROLE_PRIMARY = 3'd1,
    ROLE_STANDBY = 3'd2,
    ROLE_ACTIVE  = 3'd3,
    ROLE_PASSIVE = 3'd4
  } role_t;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_PEER   = 2'd1;
  localparam logic [1:0] REQ_CLIENT = 2'd2;

  localparam logic [2:0] EV_INVALID = 3'd0;
  localparam logic [2:0] EV_PRIMARY = 3'd1;
  localparam logic [2:0] EV_STANDBY = 3'd2;
  localparam logic [2:0] EV_ACTIVE  = 3'd3;
  localparam logic [2:0] EV_PASSIVE = 3'd4;
  localparam logic [2:0] EV_CLIENT  = 3'd5;

  localparam logic CFG_START_ROLE = 1'b0;
  localparam logic CFG_HB_PERIOD  = 1'b1;

  localparam logic [1:0]  RESET_START_ROLE = 2'd1;
  localparam logic [15:0] RESET_HB_PERIOD  = 16'd1000;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] peer_state;
  } in_item_t;

  typedef struct packed {
    logic       rejected;
    logic       fatal;
    logic [2:0] role;
    logic [2:0] last_event;
    logic       send_heartbeat;
  } out_item_t;

  // Timer controls from the role logic, valid in the cycle of an accepted request.
  typedef struct packed {
    logic tick;
    logic reload_expiry;
  } tmr_ctl_t;

endpackage

// ===== sv/failover_pair_state_machine_unit.sv =====
// Failover pair role unit: one result per request, written to the result
// register as the request is accepted. Throughput 1 request per
// cycle; the result register decouples the channels so a new request is taken
// whenever the result register is empty or being drained.
// Synchronous active-low reset: role = primary, heartbeat period 1000,
// countdowns reloaded, halt flag and last event cleared, no result pending.
// Depends on fpsm_pkg, fpsm_role and fpsm_timer.
`timescale 1ns / 1ps

module failover_pair_state_machine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpsm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fpsm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  logic                accept;
  fpsm_pkg::tmr_ctl_t  tmr_ctl;
  logic                expired, heartbeat;
  logic                rejected, fatal;
  logic [2:0]          role, last_event;
  fpsm_pkg::out_item_t result;
  logic                out_valid_r, out_valid_nxt;
  fpsm_pkg::out_item_t out_data_r, out_data_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  fpsm_role u_role (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_data),
    .expired    (expired),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata[1:0]),
    .tmr_ctl    (tmr_ctl),
    .rejected   (rejected),
    .fatal      (fatal),
    .role       (role),
    .last_event (last_event)
  );

  fpsm_timer u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tmr_ctl),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .expired   (expired),
    .heartbeat (heartbeat)
  );

  assign result = {rejected, fatal, role, last_event, heartbeat};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds while stalled; no reset needed.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/fpsm_timer.sv =====
// Heartbeat and peer expiry countdowns, plus the heartbeat period register.
// Depends on fpsm_pkg for the timer control struct and register codes.
`timescale 1ns / 1ps

module fpsm_timer (
  input  logic             clk,
  input  logic             rst_n,
  input  fpsm_pkg::tmr_ctl_t ctl,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [15:0]      cfg_wdata,
  output logic             expired,
  output logic             heartbeat
);

  logic [15:0] period_r, period_nxt;
  logic [15:0] hb_cnt_r, hb_cnt_nxt;
  logic [16:0] expiry_r, expiry_nxt;

  assign expired   = (expiry_r == 17'd0);
  assign heartbeat = ctl.tick && (hb_cnt_r <= 16'd1);

  always_comb begin
    period_nxt = period_r;
    hb_cnt_nxt = hb_cnt_r;
    expiry_nxt = expiry_r;
    if (cfg_we && cfg_addr == fpsm_pkg::CFG_HB_PERIOD) begin
      period_nxt = cfg_wdata;
      hb_cnt_nxt = cfg_wdata;
      expiry_nxt = {cfg_wdata, 1'b0};
    end else if (ctl.tick) begin
      if (!expired) begin
        expiry_nxt = expiry_r - 17'd1;
      end
      if (hb_cnt_r <= 16'd1) begin
        hb_cnt_nxt = period_r;
      end else begin
        hb_cnt_nxt = hb_cnt_r - 16'd1;
      end
    end else if (ctl.reload_expiry) begin
      expiry_nxt = {period_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= fpsm_pkg::RESET_HB_PERIOD;
      hb_cnt_r <= fpsm_pkg::RESET_HB_PERIOD;
      expiry_r <= {fpsm_pkg::RESET_HB_PERIOD, 1'b0};
    end else begin
      period_r <= period_nxt;
      hb_cnt_r <= hb_cnt_nxt;
      expiry_r <= expiry_nxt;
    end
  end

endmodule

// ===== sv/fpsm_role.sv =====
// Role state machine: peer and client event checks, halt flag, last event.
// Depends on fpsm_pkg for role, event and request codes and the item structs.
`timescale 1ns / 1ps

module fpsm_role (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  fpsm_pkg::in_item_t  item,
  input  logic                expired,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [1:0]          cfg_wdata,
  output fpsm_pkg::tmr_ctl_t  tmr_ctl,
  output logic                rejected,
  output logic                fatal,
  output logic [2:0]          role,
  output logic [2:0]          last_event
);

  fpsm_pkg::role_t role_r, role_nxt;
  logic [2:0]      event_r, event_nxt;
  logic            halted_r, halted_nxt;
  logic            is_peer, is_client, checked;
  logic [2:0]      ev;
  logic            fail;

  assign is_peer   = accept && !halted_r && item.req_type == fpsm_pkg::REQ_PEER;
  assign is_client = accept && !halted_r && item.req_type == fpsm_pkg::REQ_CLIENT;
  assign checked   = is_peer || is_client;

  // Out-of-range peer roles count as an invalid event.
  always_comb begin
    if (is_client) begin
      ev = fpsm_pkg::EV_CLIENT;
    end else if (item.peer_state > fpsm_pkg::EV_PASSIVE) begin
      ev = fpsm_pkg::EV_INVALID;
    end else begin
      ev = item.peer_state;
    end
  end

  // Next role.
  always_comb begin
    role_nxt = role_r;
    if (cfg_we && cfg_addr == fpsm_pkg::CFG_START_ROLE) begin
      role_nxt = fpsm_pkg::role_t'({1'b0, cfg_wdata});
    end else if (checked) begin
      case (role_r)
        fpsm_pkg::ROLE_PRIMARY: begin
          if (ev == fpsm_pkg::EV_STANDBY) begin
            role_nxt = fpsm_pkg::ROLE_ACTIVE;
          end else if (ev == fpsm_pkg::EV_ACTIVE) begin
            role_nxt = fpsm_pkg::ROLE_PASSIVE;
          end
        end
        fpsm_pkg::ROLE_STANDBY: begin
          if (ev == fpsm_pkg::EV_ACTIVE) begin
            role_nxt = fpsm_pkg::ROLE_PASSIVE;
          end
        end
        fpsm_pkg::ROLE_PASSIVE: begin
          // Fail over on a peer that restarted, or on a client once the peer went silent.
          if (ev == fpsm_pkg::EV_PRIMARY || ev == fpsm_pkg::EV_STANDBY ||
              (ev == fpsm_pkg::EV_CLIENT && expired)) begin
            role_nxt = fpsm_pkg::ROLE_ACTIVE;
          end
        end
        default: role_nxt = role_r;
      endcase
    end
  end

  // Check outcome and flags.
  always_comb begin
    fail = 1'b0;
    if (checked) begin
      case (role_r)
        fpsm_pkg::ROLE_STANDBY: fail = (ev == fpsm_pkg::EV_CLIENT);
        fpsm_pkg::ROLE_ACTIVE:  fail = (ev == fpsm_pkg::EV_ACTIVE);
        fpsm_pkg::ROLE_PASSIVE: fail = (ev == fpsm_pkg::EV_PASSIVE) ||
                                       (ev == fpsm_pkg::EV_CLIENT && !expired);
        default:                fail = 1'b0;
      endcase
    end
    event_nxt  = checked ? ev : event_r;
    halted_nxt = halted_r || (is_peer && fail);
    rejected   = halted_r || fail;
    tmr_ctl.tick = accept && !halted_r && item.req_type == fpsm_pkg::REQ_TICK;
    tmr_ctl.reload_expiry = is_peer && !fail;
  end

  assign fatal      = halted_nxt;
  assign role       = role_nxt;
  assign last_event = event_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r   <= fpsm_pkg::role_t'({1'b0, fpsm_pkg::RESET_START_ROLE});
      event_r  <= fpsm_pkg::EV_INVALID;
      halted_r <= 1'b0;
    end else begin
      role_r   <= role_nxt;
      event_r  <= event_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== sv/fpsm_chk.sv =====
// Port-level checker for the failover pair role unit, bound to the top level.
// Depends on fpsm_pkg and failover_pair_state_machine_unit_defines.svh.
`timescale 1ns / 1ps
`include "failover_pair_state_machine_unit_defines.svh"

module fpsm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fpsm_pkg::out_item_t out_data
);

  `FPSM_ASSERT_NEXT(a_fatal_sticky, out_valid && out_data.fatal, !out_valid || out_data.fatal, "fatal result followed by a non-fatal one")

  `FPSM_ASSERT_SAME(a_hb_clean, out_valid && out_data.send_heartbeat, !out_data.rejected && !out_data.fatal, "heartbeat on a rejected or fatal result")

  `FPSM_ASSERT_SAME(a_event_range, out_valid, out_data.last_event != 3'd6 && out_data.last_event != 3'd7, "last event code out of range")

  `FPSM_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "request refused with no result pending")

  `FPSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result dropped or changed")

endmodule

bind failover_pair_state_machine_unit fpsm_chk u_fpsm_chk (.*);
